FILE: hw/rtl/escape_time_fractal_point_assert.svh
// assertion macros used by escape_time_fractal_point.sv
`ifndef ESCAPE_TIME_FRACTAL_POINT_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_POINT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ETFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ETFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/etfp_pkg.sv
`timescale 1ns / 1ps

package etfp_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FRAC_W       = 28;
  localparam int unsigned STEPS_W      = 5;
  localparam int unsigned MAX_ITER_DEF = 17;
  localparam int unsigned CFG_IDX_W    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_RE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C_IM = 2'd2;

  // escape box edge, 2.0 in q4.28
  localparam logic signed [DATA_W-1:0] BOX_LIMIT = 32'sh2000_0000;

  // data handed from one iteration cell to the next
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [DATA_W-1:0] zr;
    logic [DATA_W-1:0] zi;
    logic [DATA_W-1:0] cr;
    logic [DATA_W-1:0] ci;
  } link_t;

  // true when either part lies outside the closed box
  function automatic logic box_escape(input logic [DATA_W-1:0] re,
                                      input logic [DATA_W-1:0] im);
    return ($signed(re) > BOX_LIMIT) || ($signed(re) < -BOX_LIMIT) ||
           ($signed(im) > BOX_LIMIT) || ($signed(im) < -BOX_LIMIT);
  endfunction

  // q4.28 multiply: full signed product, shift right by the fraction, keep 32 bits
  function automatic logic [DATA_W-1:0] q_mul(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic signed [DATA_W-1:0]   sa;
    logic signed [DATA_W-1:0]   sb;
    logic signed [2*DATA_W-1:0] p;
    sa = a;
    sb = b;
    p  = sa * sb;
    return p[FRAC_W+DATA_W-1:FRAC_W];
  endfunction

endpackage

FILE: hw/rtl/etfp_cell.sv
`timescale 1ns / 1ps

// one iteration: escape test and products, then the sums
module etfp_cell #(
  parameter int unsigned CNT_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  etfp_pkg::link_t      link_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output etfp_pkg::link_t      link_o,
  output logic [CNT_W-1:0]     cnt_o
);

  logic                        v1_q;
  logic                        done1_q, done1_d;
  logic [etfp_pkg::DATA_W-1:0] rr_q, ii_q, ri_q, cr1_q, ci1_q;
  logic [CNT_W-1:0]            cnt1_q;

  logic                        v2_q;
  logic                        done2_q;
  logic [etfp_pkg::DATA_W-1:0] zr2_q, zr2_d, zi2_q, zi2_d, cr2_q, ci2_q;
  logic [CNT_W-1:0]            cnt2_q, cnt2_d;

  assign done1_d = link_i.done | etfp_pkg::box_escape(link_i.zr, link_i.zi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= link_i.valid;
      v2_q <= v1_q;
    end
  end

  // stage one: products registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      done1_q <= done1_d;
      rr_q    <= etfp_pkg::q_mul(link_i.zr, link_i.zr);
      ii_q    <= etfp_pkg::q_mul(link_i.zi, link_i.zi);
      ri_q    <= etfp_pkg::q_mul(link_i.zr, link_i.zi);
      cr1_q   <= link_i.cr;
      ci1_q   <= link_i.ci;
      cnt1_q  <= cnt_i;
    end
  end

  // stage two: new z, count bumped unless escaped already
  assign zr2_d  = rr_q - ii_q + cr1_q;
  assign zi2_d  = ri_q + ri_q + ci1_q;
  assign cnt2_d = done1_q ? cnt1_q : cnt1_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      done2_q <= done1_q;
      zr2_q   <= zr2_d;
      zi2_q   <= zi2_d;
      cr2_q   <= cr1_q;
      ci2_q   <= ci1_q;
      cnt2_q  <= cnt2_d;
    end
  end

  assign link_o.valid = v2_q;
  assign link_o.done  = done2_q;
  assign link_o.zr    = zr2_q;
  assign link_o.zi    = zi2_q;
  assign link_o.cr    = cr2_q;
  assign link_o.ci    = ci2_q;
  assign cnt_o        = cnt2_q;

endmodule

FILE: hw/rtl/escape_time_fractal_point.sv
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    point_real_i, point_imag_i
// out      output     out_valid_o / out_ready_i  escape_steps_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// each iteration cell has a product stage and a sum stage
// the chain takes one item per cycle for as long as results are taken at the far end and no cfg write waits
// a result held at the output freezes the whole chain and drops in_ready_o
// reset clears the valid bits, the fill count and the configuration registers
// cfg is ready only once the chain is empty; a waiting cfg write holds off new items

`include "escape_time_fractal_point_assert.svh"

module escape_time_fractal_point #(
  parameter int unsigned MAX_ITERATIONS = etfp_pkg::MAX_ITER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [etfp_pkg::DATA_W-1:0] point_real_i,
  input  logic signed [etfp_pkg::DATA_W-1:0] point_imag_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [etfp_pkg::STEPS_W-1:0]     escape_steps_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [etfp_pkg::DATA_W-1:0]      cfg_data_i
);

  // step counter wide enough to hold the cap itself
  localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);
  // items in flight, up to one per stage
  localparam int unsigned FILL_W = $clog2(2 * MAX_ITERATIONS + 1);

  logic                        julia_mode_q;
  logic [etfp_pkg::DATA_W-1:0] julia_c_re_q;
  logic [etfp_pkg::DATA_W-1:0] julia_c_im_q;

  etfp_pkg::link_t  link   [MAX_ITERATIONS+1];
  logic [CNT_W-1:0] cnt_lk [MAX_ITERATIONS+1];
  logic             en;
  logic             in_acc;
  logic             out_acc;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W+etfp_pkg::STEPS_W-1:0] steps_wide;

  // configuration registers, written only while the chain is empty
  assign cfg_ready_o = (fill_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_mode_q <= 1'b0;
      julia_c_re_q <= '0;
      julia_c_im_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        etfp_pkg::REG_MODE: julia_mode_q <= cfg_data_i[0];
        etfp_pkg::REG_C_RE: julia_c_re_q <= cfg_data_i;
        etfp_pkg::REG_C_IM: julia_c_im_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the chain moves unless a finished result is held
  assign en         = !link[MAX_ITERATIONS].valid || out_ready_i;
  assign in_ready_o = en && !cfg_valid_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  // fill count, tells the cfg side when the chain has drained
  always_comb begin
    fill_d = fill_q;
    if (in_acc && !out_acc) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (out_acc && !in_acc) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // head of the chain: mandelbrot starts z at c, julia takes c from registers
  assign link[0].valid = in_acc;
  assign link[0].done  = 1'b0;
  assign link[0].zr    = point_real_i;
  assign link[0].zi    = point_imag_i;
  assign link[0].cr    = julia_mode_q ? julia_c_re_q : point_real_i;
  assign link[0].ci    = julia_mode_q ? julia_c_im_q : point_imag_i;
  assign cnt_lk[0]     = '0;

  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_iter
    etfp_cell #(
      .CNT_W (CNT_W)
    ) u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .link_i (link[g]),
      .cnt_i  (cnt_lk[g]),
      .link_o (link[g+1]),
      .cnt_o  (cnt_lk[g+1])
    );
  end

  // last cell's sum stage is the output register; count masked to the field width
  assign out_valid_o    = link[MAX_ITERATIONS].valid;
  assign steps_wide     = {{etfp_pkg::STEPS_W{1'b0}}, cnt_lk[MAX_ITERATIONS]};
  assign escape_steps_o = steps_wide[etfp_pkg::STEPS_W-1:0];

  // count never passes the cap
  `ETFP_ASSERT_IMP(a_cnt_cap, out_valid_o, cnt_lk[MAX_ITERATIONS] <= CNT_W'(MAX_ITERATIONS))
  // a point that never escaped ran every iteration
  `ETFP_ASSERT_IMP(a_full_run, out_valid_o && !link[MAX_ITERATIONS].done,
                   cnt_lk[MAX_ITERATIONS] == CNT_W'(MAX_ITERATIONS))
  // a held result blocks new items
  `ETFP_ASSERT_IMP(a_stall, out_valid_o && !out_ready_i, !in_ready_o)
  // mode write lands in the register
  `ETFP_ASSERT_NXT(a_mode_wr, cfg_valid_i && cfg_ready_o && cfg_index_i == etfp_pkg::REG_MODE,
                   julia_mode_q == $past(cfg_data_i[0]))

endmodule
